>>> hw/rtl/ipd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants of the pulse distance infrared frame decoder.
// ----------------------------------------------------------------------------
package ipd_pkg;

	// nominal durations in microseconds
	localparam int unsigned HDR_MARK   = 8000;
	localparam int unsigned HDR_SPACE  = 4000;
	localparam int unsigned BIT_MARK   = 600;
	localparam int unsigned ONE_SPACE  = 1600;
	localparam int unsigned ZERO_SPACE = 550;

	localparam int unsigned TOL_MAX    = 100;

	localparam int DUR_W    = 16;
	localparam int TOL_W    = 7;
	localparam int EXCESS_W = 10;
	localparam int TGT_W    = 14;   // largest target: header mark plus full excess
	localparam int FACTOR_W = 8;    // 100 +/- tolerance
	localparam int CMP_W    = 23;   // 100 * duration + 99
	localparam int VALUE_W  = 16;
	localparam int STATUS_W = 2;

	localparam int QUEUE_DEPTH = 4;

	// match windows held by the front end
	localparam int TGT_HDR_MARK   = 0;
	localparam int TGT_HDR_SPACE  = 1;
	localparam int TGT_BIT_MARK   = 2;
	localparam int TGT_ONE_SPACE  = 3;
	localparam int TGT_ZERO_SPACE = 4;
	localparam int NUM_TGT        = 5;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_FAIL   = 2'd0,
		STATUS_DATA   = 2'd1,
		STATUS_REPEAT = 2'd2
	} ipd_status_t;

	typedef enum logic {
		CFG_TOLERANCE   = 1'b0,
		CFG_MARK_EXCESS = 1'b1
	} ipd_cfg_idx_t;

	// one classified duration
	typedef struct packed {
		logic hdr_mark;
		logic hdr_space;
		logic bit_mark;
		logic one_space;
		logic zero_space;
		logic last;
	} ipd_class_t;

endpackage

>>> hw/rtl/ir_pulse_distance_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_pulse_distance_frame_decoder_unit
// Decodes pulse distance infrared frames (header, data bits, stop mark, or
// a header-less repeat) from a stream of measured mark/space durations.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake        Payload
// s_axis    in   tvalid/tready    tdata[15:0] duration_us, tlast last_in_frame
// m_axis    out  tvalid/tready    tdata[15:0] value, tuser[1:0] status
// cfg       in   valid/ready      index 0 tolerance_percent, 1 mark_excess_us
//
// One duration is accepted per cycle while s_axis_tready is high. With an
// empty queue and a free result register, a frame result shows on m_axis
// once the last duration of the frame has passed the input register, a queue
// entry and the sequencer into the result register.
// Reset restores tolerance 25 and mark excess 100 and clears the frame state.
// A stalled m_axis holds the result; durations keep flowing into the
// four-entry queue until it fills, and only then s_axis_tready drops.
// cfg_ready is always high; windows follow a write via the product registers.
// ----------------------------------------------------------------------------
module ir_pulse_distance_frame_decoder_unit import ipd_pkg::*; #(
	parameter int DATA_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	input  logic [15:0]         s_axis_tdata,   // [15:0] duration_us
	input  logic                s_axis_tlast,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [15:0]         m_axis_tdata,   // [15:0] value
	output logic [1:0]          m_axis_tuser,   // [1:0] status
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [EXCESS_W-1:0] cfg_data
);

	logic [TOL_W-1:0]    tolerance_q;
	logic [EXCESS_W-1:0] mark_excess_q;
	logic                q_push;
	logic                q_pop;
	logic                q_empty;
	logic                q_full;
	ipd_class_t          q_in;
	ipd_class_t          q_head;
	logic [STATUS_W-1:0] status;
	logic [VALUE_W-1:0]  value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q   <= TOL_W'(25);
			mark_excess_q <= EXCESS_W'(100);
		end else if (cfg_valid) begin
			case (ipd_cfg_idx_t'(cfg_index))
				CFG_TOLERANCE:   tolerance_q   <= cfg_data[TOL_W-1:0];
				CFG_MARK_EXCESS: mark_excess_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ipd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.tolerance   (tolerance_q),
		.mark_excess (mark_excess_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_duration (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_in)
	);

	ipd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty),
		.full      (q_full)
	);

	ipd_back #(
		.DATA_BITS (DATA_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.empty      (q_empty),
		.pop        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (status),
		.out_value  (value)
	);

	assign m_axis_tdata = value;
	assign m_axis_tuser = status;

	// a result only appears after a frame end left the queue
	a_result_from_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(q_pop && q_head.last))
		else $error("result without frame end");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("queue popped while empty");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && q_pop) |-> !q_head.last)
		else $error("pending result overwritten");

endmodule

>>> hw/rtl/ipd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_front
// Takes durations, compares them against the five match windows and pushes
// one set of match flags per duration into the queue.
// ----------------------------------------------------------------------------
module ipd_front import ipd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [TOL_W-1:0]    tolerance,
	input  logic [EXCESS_W-1:0] mark_excess,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [DUR_W-1:0]    in_duration,
	input  logic                in_last,
	input  logic                q_full,
	output logic                q_push,
	output ipd_class_t          q_data
);

	logic [TOL_W-1:0]    tol_sat;
	logic [FACTOR_W-1:0] lo_factor;
	logic [FACTOR_W-1:0] hi_factor;
	logic [TGT_W-1:0]    target [NUM_TGT];
	logic [CMP_W-1:0]    lo_prod_q [NUM_TGT];
	logic [CMP_W-1:0]    hi_prod_q [NUM_TGT];
	logic [NUM_TGT-1:0]  match;

	logic                valid_s1;
	logic [CMP_W-1:0]    d100_s1;
	logic                last_s1;

	function automatic logic [TGT_W-1:0] space_target(input int unsigned nominal,
			input logic [EXCESS_W-1:0] excess);
		logic [TGT_W-1:0] nom;
		nom = TGT_W'(nominal);
		return (nom > TGT_W'(excess)) ? nom - TGT_W'(excess) : '0;
	endfunction

	assign tol_sat   = (tolerance > TOL_W'(TOL_MAX)) ? TOL_W'(TOL_MAX) : tolerance;
	assign lo_factor = FACTOR_W'(TOL_MAX) - FACTOR_W'(tol_sat);
	assign hi_factor = FACTOR_W'(TOL_MAX) + FACTOR_W'(tol_sat);

	assign target[TGT_HDR_MARK]   = TGT_W'(HDR_MARK) + TGT_W'(mark_excess);
	assign target[TGT_BIT_MARK]   = TGT_W'(BIT_MARK) + TGT_W'(mark_excess);
	assign target[TGT_HDR_SPACE]  = space_target(HDR_SPACE, mark_excess);
	assign target[TGT_ONE_SPACE]  = space_target(ONE_SPACE, mark_excess);
	assign target[TGT_ZERO_SPACE] = space_target(ZERO_SPACE, mark_excess);

	// Window products follow the config registers in the next cycle. The floor
	// of the /100 is folded into the compare: lo <= d  <=>  t*f_lo <= 100d+99,
	// d <= hi  <=>  100d <= t*f_hi.
	always_ff @(posedge clk) begin
		for (int i = 0; i < NUM_TGT; i++) begin
			lo_prod_q[i] <= CMP_W'(CMP_W'(target[i]) * CMP_W'(lo_factor));
			hi_prod_q[i] <= CMP_W'(CMP_W'(target[i]) * CMP_W'(hi_factor));
		end
	end

	assign in_ready = !valid_s1 || !q_full;
	assign q_push   = valid_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d100_s1 <= CMP_W'({in_duration, 6'b0}) + CMP_W'({in_duration, 5'b0})
				+ CMP_W'({in_duration, 2'b0});
			last_s1 <= in_last;
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_TGT; i++) begin
			match[i] = (lo_prod_q[i] <= d100_s1 + CMP_W'(99)) && (d100_s1 <= hi_prod_q[i]);
		end
	end

	assign q_data.hdr_mark   = match[TGT_HDR_MARK];
	assign q_data.hdr_space  = match[TGT_HDR_SPACE];
	assign q_data.bit_mark   = match[TGT_BIT_MARK];
	assign q_data.one_space  = match[TGT_ONE_SPACE];
	assign q_data.zero_space = match[TGT_ZERO_SPACE];
	assign q_data.last       = last_s1;

endmodule

>>> hw/rtl/ipd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_queue
// Short FIFO of classified durations between front end and frame sequencer.
// ----------------------------------------------------------------------------
module ipd_queue import ipd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  ipd_class_t push_data,
	input  logic       pop,
	output ipd_class_t head,
	output logic       empty,
	output logic       full
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	ipd_class_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/ipd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipd_back
// Frame sequencer: walks the frame positions, shifts in data bits and
// drives the result register at frame end.
// ----------------------------------------------------------------------------
module ipd_back import ipd_pkg::*; #(
	parameter int DATA_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ipd_class_t         head,
	input  logic               empty,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [STATUS_W-1:0] out_status,
	output logic [VALUE_W-1:0] out_value
);

	localparam int FRAME_LEN  = 2 * DATA_BITS + 3;
	localparam int REPEAT_LEN = 2 * DATA_BITS + 1;
	localparam int POS_W      = $clog2(FRAME_LEN + 1);

	logic [POS_W-1:0]     pos_q, pos_n;
	logic [DATA_BITS-1:0] shift_q, shift_n;
	logic                 ok_q, ok_n;
	logic                 first_bm_q, first_bm_n;
	logic                 last_bm_n;
	logic                 out_free;
	ipd_status_t          status_n;
	logic [VALUE_W-1:0]   value_n;
	logic [VALUE_W-1:0]   shift_low;

	generate
		if (DATA_BITS >= VALUE_W) begin : g_value_trunc
			assign shift_low = shift_n[VALUE_W-1:0];
		end else begin : g_value_ext
			assign shift_low = VALUE_W'(shift_n);
		end
	endgenerate

	assign out_free = !out_valid || out_ready;
	// a frame end only leaves the queue once the result register is free
	assign pop      = !empty && (!head.last || out_free);

	always_comb begin
		pos_n      = pos_q;
		shift_n    = shift_q;
		ok_n       = ok_q;
		first_bm_n = first_bm_q;
		last_bm_n  = head.bit_mark;
		if (pos_q == '0) begin
			first_bm_n = head.bit_mark;
			if (!head.hdr_mark) ok_n = 1'b0;
		end else if (pos_q == POS_W'(1)) begin
			if (!head.hdr_space) ok_n = 1'b0;
		end else if (pos_q < POS_W'(FRAME_LEN - 1)) begin
			if (!pos_q[0]) begin
				if (!head.bit_mark) ok_n = 1'b0;
			end else if (head.one_space) begin
				shift_n = {shift_q[DATA_BITS-2:0], 1'b1};
			end else if (head.zero_space) begin
				shift_n = {shift_q[DATA_BITS-2:0], 1'b0};
			end else begin
				ok_n = 1'b0;
			end
		end else if (pos_q == POS_W'(FRAME_LEN - 1)) begin
			if (!head.bit_mark) ok_n = 1'b0;
		end
		if (pos_q < POS_W'(FRAME_LEN)) begin
			pos_n = pos_q + 1'b1;
		end

		status_n = STATUS_FAIL;
		value_n  = '0;
		if (pos_n == POS_W'(REPEAT_LEN) && first_bm_n && last_bm_n) begin
			status_n = STATUS_REPEAT;
		end else if (pos_n == POS_W'(FRAME_LEN) && ok_n) begin
			status_n = STATUS_DATA;
			value_n  = shift_low;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			shift_q    <= '0;
			ok_q       <= 1'b1;
			first_bm_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			if (pop) begin
				if (head.last) begin
					pos_q      <= '0;
					shift_q    <= '0;
					ok_q       <= 1'b1;
					first_bm_q <= 1'b0;
				end else begin
					pos_q      <= pos_n;
					shift_q    <= shift_n;
					ok_q       <= ok_n;
					first_bm_q <= first_bm_n;
				end
			end
			if (pop && head.last) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			out_status <= status_n;
			out_value  <= value_n;
		end
	end

endmodule
